[sv/damt_pkg.sv]
package damt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int CMD_W = 2;
    localparam int KEY_W = 8;
    localparam int VAL_W = 16;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
        logic hit;
        logic scan_done;
        logic out_busy;
    } t_dp_stat;

endpackage

[sv/damt_ctrl.sv]
module damt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_accept,
    input  damt_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output damt_pkg::t_dp_cmd o_cmd
);
    import damt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_accept) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.skip || i_stat.hit || i_stat.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // Wait until the output register can take the result.
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/damt_dp.sv]
module damt_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  damt_pkg::t_dp_cmd               i_cmd,
    output damt_pkg::t_dp_stat              o_stat,
    input  logic [damt_pkg::CMD_W-1:0]      i_command,
    input  logic [damt_pkg::KEY_W-1:0]      i_device_key,
    input  logic [damt_pkg::VAL_W-1:0]      i_short_value,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [damt_pkg::VAL_W-1:0]      o_read_value,
    output logic [damt_pkg::ST_W-1:0]       o_status
);
    import damt_pkg::*;

    // Latched command.
    logic [CMD_W-1:0] r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;

    // Entry store: key and value share one word.
    logic [KEY_W+VAL_W-1:0] mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [VAL_W-1:0] r_kz_val;

    // Scan state.
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_pend;
    logic [IDX_W-1:0]       r_q_idx;
    logic [KEY_W+VAL_W-1:0] r_q;
    logic                   r_hit;
    logic [IDX_W-1:0]       r_hit_idx;
    logic [VAL_W-1:0]       r_hit_val;
    logic                   r_free_ok;
    logic [IDX_W-1:0]       r_free_idx;

    // Output register.
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_rd;
    logic [ST_W-1:0]  r_out_st;

    logic                   cnt_end;
    logic                   key_zero;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [VAL_W-1:0]       res_rd;
    logic [ST_W-1:0]        res_st;

    assign cnt_end  = (r_cnt == CNT_W'(TABLE_ENTRIES));
    assign key_zero = (r_key == '0);

    assign o_stat.skip      = (r_cmd == CMD_CLEAR) || key_zero;
    assign o_stat.hit       = r_hit;
    assign o_stat.scan_done = cnt_end && !r_pend;
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;

    // Result of the finished search and the store update it implies.
    always_comb begin
        res_rd    = '0;
        res_st    = ST_OK;
        mem_we    = 1'b0;
        mem_waddr = r_hit_idx;
        case (r_cmd)
            CMD_SET: begin
                if (!key_zero) begin
                    if (r_hit) begin
                        mem_we = 1'b1;
                    end else if (r_free_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_free_idx;
                    end else begin
                        res_st = ST_FULL;
                    end
                end
            end
            CMD_DELETE: begin
                if (key_zero || !r_hit) begin
                    res_st = ST_NOT_FOUND;
                end
            end
            CMD_LOOKUP: begin
                if (key_zero) begin
                    res_rd = r_kz_val;
                end else if (r_hit) begin
                    res_rd = r_hit_val;
                end else begin
                    res_st = ST_NOT_FOUND;
                end
            end
            default: begin
                res_rd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_key <= i_device_key;
            r_val <= i_short_value;
        end
        if (i_cmd.commit && mem_we) begin
            mem[mem_waddr] <= {r_key, r_val};
        end
        if (i_cmd.scan_step && !cnt_end) begin
            r_q     <= mem[r_cnt[IDX_W-1:0]];
            r_q_idx <= r_cnt[IDX_W-1:0];
        end
        if (r_pend && r_valid[r_q_idx] && r_q[KEY_W+VAL_W-1:VAL_W] == r_key) begin
            r_hit_idx <= r_q_idx;
            r_hit_val <= r_q[VAL_W-1:0];
        end
        if (r_pend && !r_valid[r_q_idx] && !r_free_ok) begin
            r_free_idx <= r_q_idx;
        end
        if (i_cmd.commit) begin
            r_out_rd <= res_rd;
            r_out_st <= res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_free_ok   <= 1'b0;
            r_valid     <= '0;
            r_kz_val    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_cnt     <= '0;
                r_pend    <= 1'b0;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pend <= !cnt_end;
                if (!cnt_end) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (r_pend && r_valid[r_q_idx]
                        && r_q[KEY_W+VAL_W-1:VAL_W] == r_key) begin
                    r_hit <= 1'b1;
                end
                if (r_pend && !r_valid[r_q_idx]) begin
                    r_free_ok <= 1'b1;
                end
            end

            if (i_cmd.commit) begin
                case (r_cmd)
                    CMD_SET: begin
                        if (key_zero) begin
                            r_kz_val <= r_val;
                        end else if (!r_hit && r_free_ok) begin
                            r_valid[r_free_idx] <= 1'b1;
                        end
                    end
                    CMD_DELETE: begin
                        if (!key_zero && r_hit) begin
                            r_valid[r_hit_idx] <= 1'b0;
                        end
                    end
                    CMD_CLEAR: begin
                        r_valid  <= '0;
                        r_kz_val <= '0;
                    end
                    default: begin
                        r_kz_val <= r_kz_val;
                    end
                endcase
            end

            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_rd;
    assign o_status     = r_out_st;

endmodule

[sv/device_address_map_table.sv]
// Device address map table: maps an 8-bit device key to a 16-bit short
// address held in a store of TABLE_ENTRIES entries (16). Each item carries a
// command in tuser (set or insert, delete, lookup, clear table) and the key and
// value in tdata; every item yields exactly one result item with the value read
// by a lookup (0 otherwise) and a status of ok, not found or table full. Key 0
// is a permanent entry that never occupies the store: set writes it, lookup
// reads it, delete answers not found, and clear returns it to 0. An item that
// needs a search reads the key store through its single read port, one entry
// per cycle, stopping at the first match; clear and key 0 commands skip the
// search. One item is worked on at a time, but a result waiting in the output
// register does not stop the next item from being accepted and searched.
// After reset the table is empty and ready at once.
module device_address_map_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // device_key [7:0], short_value [23:8]
    input  logic [1:0]  s_axis_tuser,   // command [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // read_value [15:0]
    output logic [1:0]  m_axis_tuser    // status [1:0]
);
    import damt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_accept;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // The controller sequences load, search and commit.
    damt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_stat      (stat),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (cmd)
    );

    // The datapath holds the store, the search registers and the result.
    damt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_command     (s_axis_tuser),
        .i_device_key  (s_axis_tdata[KEY_W-1:0]),
        .i_short_value (s_axis_tdata[KEY_W+VAL_W-1:KEY_W]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_read_value  (m_axis_tdata),
        .o_status      (m_axis_tuser)
    );

endmodule

[verif/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import damt_pkg::*;

    // One result item as the block reports it.
    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [ST_W-1:0]  status;
    } t_map_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata;   // device_key [7:0], short_value [23:8]
    logic [1:0]        s_axis_tuser;   // command [1:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;   // read_value [15:0]
    logic [1:0]        m_axis_tuser;   // status [1:0]

    // The testbench's own copy of the table. Key 0 lives apart from the store,
    // exactly as the block keeps it.
    logic              map_used [TABLE_ENTRIES];
    logic [KEY_W-1:0]  map_key  [TABLE_ENTRIES];
    logic [VAL_W-1:0]  map_val  [TABLE_ENTRIES];
    logic [VAL_W-1:0]  key0_val;

    // Results still owed by the block, oldest first.
    t_map_result       pending_results [$];
    int                mismatch_count;

    // When pace_on is low neither side idles. A nonzero hold-off request makes
    // the receiver drop tready, counting the request down to zero.
    bit                pace_on;
    int                hold_off_request;

    device_address_map_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Most gaps are nil or short; now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Store entry holding the key, or -1 when the key is absent.
    function automatic int locate_key(input logic [KEY_W-1:0] key);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (map_used[i] && map_key[i] == key) return i;
        end
        return -1;
    endfunction

    // Applies one accepted command to the local table and queues the result
    // that the block must return for it.
    function automatic void predict_table_step(input logic [CMD_W-1:0] cmd,
                                               input logic [KEY_W-1:0] key,
                                               input logic [VAL_W-1:0] val);
        t_map_result res;
        int          slot;
        res.read_value = '0;
        res.status     = ST_OK;
        case (cmd)
            CMD_SET: begin
                if (key == '0) begin
                    key0_val = val;
                end else begin
                    slot = locate_key(key);
                    if (slot < 0) begin
                        // The lowest free entry takes a new key.
                        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                            if (!map_used[i]) slot = i;
                        end
                        if (slot >= 0) begin
                            map_used[slot] = 1'b1;
                            map_key[slot]  = key;
                        end
                    end
                    if (slot < 0) res.status = ST_FULL;
                    else map_val[slot] = val;
                end
            end
            CMD_DELETE: begin
                // Key 0 is permanent, so deleting it is reported as not found.
                slot = (key == '0) ? -1 : locate_key(key);
                if (slot < 0) res.status = ST_NOT_FOUND;
                else map_used[slot] = 1'b0;
            end
            CMD_LOOKUP: begin
                if (key == '0) begin
                    res.read_value = key0_val;
                end else begin
                    slot = locate_key(key);
                    if (slot < 0) res.status = ST_NOT_FOUND;
                    else res.read_value = map_val[slot];
                end
            end
            default: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) map_used[i] = 1'b0;
                key0_val = '0;
            end
        endcase
        pending_results.push_back(res);
    endfunction

    // Prints one line for each mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t ns: %s, got %h, expected %h", $time, what,
                 got, want);
        mismatch_count++;
    endtask

    task automatic check_result(input logic [15:0] rv, input logic [1:0] st);
        t_map_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result item with nothing outstanding", rv, '0);
            return;
        end
        want = pending_results.pop_front();
        if (rv !== want.read_value) report_mismatch("read_value", rv, want.read_value);
        if (st !== want.status) report_mismatch("status", 16'(st), 16'(want.status));
    endtask

    // Receiver: checks each accepted result and drives tready. Both the check
    // and the new tready value use what was on the wires just before the edge.
    initial begin
        int run_left;
        int hold_left;
        run_left  = 0;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
                check_result(m_axis_tdata, m_axis_tuser);
            end
            if (hold_off_request != 0) begin
                hold_left = hold_off_request;
                hold_off_request <= 0;
                run_left = 0;
            end
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!pace_on) begin
                m_axis_tready <= 1'b1;
            end else if (run_left > 0) begin
                run_left--;
            end else if ($urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                run_left = pick_gap();
            end else begin
                m_axis_tready <= 1'b1;
                run_left = $urandom_range(0, 10);
            end
        end
    end

    // Offers one item, optionally after an idle gap, and waits for it to be
    // taken. tvalid stays high straight into the next item when there is no
    // gap, so it is never lowered and raised within one edge.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val);
        int gap;
        gap = pace_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, key};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_table_step(cmd, key, val);
    endtask

    // Key 0 is the permanent entry: it reads 0 after reset, set writes it and
    // delete must leave it in place.
    task automatic test_key_zero();
        send_item(CMD_LOOKUP, 8'h00, 16'hFFFF);
        send_item(CMD_SET,    8'h00, 16'hFFFF);
        send_item(CMD_DELETE, 8'h00, 16'h0000);
        send_item(CMD_LOOKUP, 8'h00, 16'h0000);
    endtask

    // Fills the store, pushes it past full, then updates, deletes and clears.
    task automatic test_fill_and_clear();
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            key = (i == 0) ? 8'hFF : KEY_W'(i);
            val = (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : VAL_W'($urandom);
            send_item(CMD_SET, key, val);
        end
        send_item(CMD_SET,    8'h80, 16'h1234);   // no room for a new key
        send_item(CMD_SET,    8'hFF, 16'h8001);   // update still allowed when full
        send_item(CMD_LOOKUP, 8'hFF, 16'h0000);
        send_item(CMD_DELETE, 8'h01, 16'h0000);
        send_item(CMD_DELETE, 8'h01, 16'h0000);   // absent key
        send_item(CMD_SET,    8'h80, 16'h5A5A);   // takes the freed entry
        send_item(CMD_LOOKUP, 8'h80, 16'hFFFF);
        send_item(CMD_LOOKUP, 8'h01, 16'h0000);
        send_item(CMD_CLEAR,  8'hFF, 16'hFFFF);
        send_item(CMD_LOOKUP, 8'hFF, 16'h0000);
        send_item(CMD_LOOKUP, 8'h00, 16'h0000);   // key 0 back to 0 after clear
    endtask

    // One random item drawn mostly from a small pool of keys, so that hits,
    // misses and a full store all occur often.
    task automatic send_random_item(input logic [KEY_W-1:0] pool_base, input int pool_size);
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        int               r;
        r = $urandom_range(0, 99);
        if (r < 45)      cmd = CMD_SET;
        else if (r < 70) cmd = CMD_LOOKUP;
        else if (r < 98) cmd = CMD_DELETE;
        else             cmd = CMD_CLEAR;
        r = $urandom_range(0, 99);
        if (r < 5)       key = '0;
        else if (r < 15) key = KEY_W'($urandom);
        else             key = KEY_W'(pool_base + $urandom_range(0, pool_size - 1));
        send_item(cmd, key, VAL_W'($urandom));
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering items back to back, so the block fills and stalls its input.
    task automatic test_output_backpressure();
        pace_on = 1'b0;
        hold_off_request <= 400;
        for (int i = 0; i < 30; i++) send_random_item(8'h40, 12);
        pace_on = 1'b1;
    endtask

    // Phases with different key pools; one phase in four runs without idling.
    task automatic test_random_traffic();
        int               pool_sizes [4] = '{6, 20, 40, 256};
        logic [KEY_W-1:0] pool_base;
        for (int phase = 0; phase < 8; phase++) begin
            pace_on   = (phase % 4) != 3;
            pool_base = KEY_W'($urandom);
            for (int i = 0; i < 200; i++) begin
                send_random_item(pool_base, pool_sizes[phase % 4]);
            end
        end
        pace_on = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            map_used[i] = 1'b0;
            map_key[i]  = '0;
            map_val[i]  = '0;
        end
        key0_val       = '0;
        mismatch_count = 0;
        pace_on        = 1'b1;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_LOOKUP;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_key_zero();
        test_fill_and_clear();
        test_output_backpressure();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // Watch a little longer for any result item that should not appear.
        repeat (TABLE_ENTRIES + 10) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
